// File: sv/pqmf_pkg.sv
// pqmf_pkg: shared types and constants of the max-first priority queue
// used by pqmf_cell and priority_queue_max_first; depends on nothing else
`default_nettype none

package pqmf_pkg;

    localparam int VALUE_W   = 32;  // stored value width
    localparam int IN_PRIO_W = 8;   // priority field width on the ports
    localparam int OCC_W     = 5;   // occupancy field width on the ports
    localparam int STATUS_W  = 2;
    localparam int IN_DATA_W  = 40; // value, priority
    localparam int OUT_DATA_W = 48; // value, priority, occupancy, padding

    localparam logic [VALUE_W-1:0] EMPTY_VALUE = '1;  // -1 on an empty dequeue

    typedef enum logic [0:0] {
        OP_ENQUEUE = 1'b0,
        OP_DEQUEUE = 1'b1
    } op_t;

    typedef enum logic [STATUS_W-1:0] {
        STATUS_OK    = 2'd0,
        STATUS_EMPTY = 2'd1,
        STATUS_FULL  = 2'd2
    } status_t;

    // per-cycle command broadcast to every cell of the chain
    typedef struct packed {
        logic enq;  // accepted enqueue that fits
        logic deq;  // accepted dequeue on a non-empty store
    } ctrl_t;

endpackage

`default_nettype wire

// File: sv/pqmf_cell.sv
// pqmf_cell: one slot of the sorted chain, holds a value and a priority
// depends on pqmf_pkg
`default_nettype none

module pqmf_cell #(
    parameter int PRIORITY_BITS = 8
) (
    input  wire logic                        clk,
    input  wire pqmf_pkg::ctrl_t             ctrl,
    input  wire logic                        occupied,
    input  wire logic [pqmf_pkg::VALUE_W-1:0] new_value,
    input  wire logic [PRIORITY_BITS-1:0]    new_prio,
    input  wire logic                        left_ge,
    input  wire logic [pqmf_pkg::VALUE_W-1:0] left_value,
    input  wire logic [PRIORITY_BITS-1:0]    left_prio,
    input  wire logic [pqmf_pkg::VALUE_W-1:0] right_value,
    input  wire logic [PRIORITY_BITS-1:0]    right_prio,
    output logic                             ge,
    output logic [pqmf_pkg::VALUE_W-1:0]     value,
    output logic [PRIORITY_BITS-1:0]         prio
);
    import pqmf_pkg::*;

    logic [VALUE_W-1:0]       value_reg;
    logic [VALUE_W-1:0]       value_next;
    logic [PRIORITY_BITS-1:0] prio_reg;
    logic [PRIORITY_BITS-1:0] prio_next;

    // entry stays ahead of a new one of equal priority
    assign ge    = occupied && (prio_reg >= new_prio);
    assign value = value_reg;
    assign prio  = prio_reg;

    always_comb
    begin
        value_next = value_reg;
        prio_next  = prio_reg;
        if (ctrl.deq)
        begin
            value_next = right_value;
            prio_next  = right_prio;
        end
        else if (ctrl.enq && !ge)
        begin
            if (left_ge)
            begin
                value_next = new_value;
                prio_next  = new_prio;
            end
            else
            begin
                value_next = left_value;
                prio_next  = left_prio;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        value_reg <= value_next;
        prio_reg  <= prio_next;
    end

endmodule

`default_nettype wire

// File: sv/priority_queue_max_first.sv
// priority_queue_max_first: top level, chain of pqmf_cell slots plus result register
// depends on pqmf_pkg and pqmf_cell
//
// usage
//   input stream (s_axis): one word per command; tuser carries the op
//     (enqueue or dequeue), tdata the value and priority of an enqueue
//   output stream (m_axis): exactly one word per command; tuser carries the
//     status (ok, empty, full), tdata the removed value and priority and the
//     occupancy after the command
//   the cells are kept sorted by priority, highest first, and among equal
//   priorities in arrival order, so the head cell is always the next to leave;
//   an enqueue inserts in place (every cell compares against the new
//   priority at once), a dequeue shifts the whole chain one place toward the head
//   latency: the result word is valid the cycle after the command is accepted
//   throughput: one command per cycle while the receiver keeps tready high;
//   the single result register sets this figure
//   reset: the store is empty, no result is pending; cell contents are left as
//   they are since only occupied cells are ever read
//   stall: while a result waits and m_axis_tready is low, s_axis_tready is low
`default_nettype none

module priority_queue_max_first #(
    parameter int DEPTH         = 16,
    parameter int PRIORITY_BITS = 8
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              s_axis_tvalid,
    output logic                                   s_axis_tready,
    input  wire logic [pqmf_pkg::IN_DATA_W-1:0]    s_axis_tdata,  // item_value, item_priority
    input  wire logic [0:0]                        s_axis_tuser,  // op
    output logic                                   m_axis_tvalid,
    input  wire logic                              m_axis_tready,
    output logic [pqmf_pkg::OUT_DATA_W-1:0]        m_axis_tdata,  // out_value, out_priority,
                                                                   // occupancy, zero pad
    output logic [pqmf_pkg::STATUS_W-1:0]          m_axis_tuser   // status
);
    import pqmf_pkg::*;

    localparam int CNT_W = $clog2(DEPTH + 1);

    logic                     accept;
    op_t                      op;
    logic [VALUE_W-1:0]       in_value;
    logic [IN_PRIO_W-1:0]     in_prio;
    logic [PRIORITY_BITS-1:0] new_prio;

    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             full;
    logic             empty;
    ctrl_t            ctrl;

    // chain wiring
    logic [VALUE_W-1:0]       cell_value [DEPTH];
    logic [PRIORITY_BITS-1:0] cell_prio  [DEPTH];
    logic                     cell_ge    [DEPTH];

    // result register
    logic                 out_valid_reg;
    logic                 out_valid_next;
    logic [VALUE_W-1:0]   out_value_reg;
    logic [VALUE_W-1:0]   out_value_next;
    logic [IN_PRIO_W-1:0] out_prio_reg;
    logic [IN_PRIO_W-1:0] out_prio_next;
    status_t              out_status_reg;
    status_t              out_status_next;
    logic [OCC_W-1:0]     out_occ_reg;
    logic [OCC_W-1:0]     out_occ_next;
    logic [IN_PRIO_W-1:0] head_prio_port;
    logic [OCC_W-1:0]     occ_port;

    assign s_axis_tready = !out_valid_reg || m_axis_tready;
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign op            = op_t'(s_axis_tuser[0]);
    assign in_value      = s_axis_tdata[VALUE_W-1:0];
    assign in_prio       = s_axis_tdata[VALUE_W +: IN_PRIO_W];

    // priority kept in its low PRIORITY_BITS bits; head priority and count
    // fitted back to the port widths
    generate
        if (PRIORITY_BITS <= IN_PRIO_W)
        begin : g_prio_narrow
            assign new_prio       = in_prio[PRIORITY_BITS-1:0];
            assign head_prio_port = IN_PRIO_W'(cell_prio[0]);
        end
        else
        begin : g_prio_wide
            assign new_prio       = PRIORITY_BITS'(in_prio);
            assign head_prio_port = cell_prio[0][IN_PRIO_W-1:0];
        end
        if (CNT_W <= OCC_W)
        begin : g_occ_narrow
            assign occ_port = OCC_W'(count_next);
        end
        else
        begin : g_occ_wide
            assign occ_port = count_next[OCC_W-1:0];
        end
    endgenerate

    assign full     = (count_reg == CNT_W'(DEPTH));
    assign empty    = (count_reg == '0);
    assign ctrl.enq = accept && (op == OP_ENQUEUE) && !full;
    assign ctrl.deq = accept && (op == OP_DEQUEUE) && !empty;

    always_comb
    begin
        count_next = count_reg;
        if (ctrl.enq)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (ctrl.deq)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    // the chain: cell 0 is the head; a new entry lands behind every entry of
    // equal or higher priority, the cells behind it shift one place back
    generate
        for (genvar i = 0; i < DEPTH; i++)
        begin : g_cell
            logic                     left_ge;
            logic [VALUE_W-1:0]       left_value;
            logic [PRIORITY_BITS-1:0] left_prio;
            logic [VALUE_W-1:0]       right_value;
            logic [PRIORITY_BITS-1:0] right_prio;

            if (i == 0)
            begin : g_head
                assign left_ge    = 1'b1;
                assign left_value = in_value;
                assign left_prio  = new_prio;
            end
            else
            begin : g_mid
                assign left_ge    = cell_ge[i-1];
                assign left_value = cell_value[i-1];
                assign left_prio  = cell_prio[i-1];
            end

            if (i == DEPTH - 1)
            begin : g_tail
                // tail slot becomes unoccupied on a dequeue
                assign right_value = cell_value[i];
                assign right_prio  = cell_prio[i];
            end
            else
            begin : g_body
                assign right_value = cell_value[i+1];
                assign right_prio  = cell_prio[i+1];
            end

            pqmf_cell #(
                .PRIORITY_BITS (PRIORITY_BITS)
            ) u_cell (
                .clk         (clk),
                .ctrl        (ctrl),
                .occupied    (CNT_W'(i) < count_reg),
                .new_value   (in_value),
                .new_prio    (new_prio),
                .left_ge     (left_ge),
                .left_value  (left_value),
                .left_prio   (left_prio),
                .right_value (right_value),
                .right_prio  (right_prio),
                .ge          (cell_ge[i]),
                .value       (cell_value[i]),
                .prio        (cell_prio[i])
            );
        end
    endgenerate

    // result word for the accepted command
    always_comb
    begin
        out_value_next  = '0;
        out_prio_next   = '0;
        out_status_next = STATUS_OK;
        out_occ_next    = occ_port;
        if (op == OP_ENQUEUE)
        begin
            if (full)
            begin
                out_status_next = STATUS_FULL;
            end
        end
        else if (empty)
        begin
            out_value_next  = EMPTY_VALUE;
            out_status_next = STATUS_EMPTY;
        end
        else
        begin
            out_value_next = cell_value[0];
            out_prio_next  = head_prio_port;
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (accept)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            out_value_reg  <= out_value_next;
            out_prio_reg   <= out_prio_next;
            out_status_reg <= out_status_next;
            out_occ_reg    <= out_occ_next;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {{(OUT_DATA_W - VALUE_W - IN_PRIO_W - OCC_W){1'b0}},
                            out_occ_reg, out_prio_reg, out_value_reg};
    assign m_axis_tuser  = out_status_reg;

    // store never holds more than DEPTH entries
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(DEPTH))
        else $error("entry count above depth");

    // head stays the largest: the chain is sorted at its front
    a_head_sorted: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg >= CNT_W'(2)) |-> (cell_prio[0] >= cell_prio[1]))
        else $error("head cell not highest priority");

    // an enqueue on a full store reports full and leaves the count alone
    a_full_drop: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && (op == OP_ENQUEUE) && full) |=>
            (out_status_reg == STATUS_FULL) && (count_reg == CNT_W'(DEPTH)))
        else $error("full enqueue not dropped");

    // a dequeue removes exactly one entry
    a_deq_count: assert property (@(posedge clk) disable iff (!rst_n)
        ctrl.deq |=> (count_reg == $past(count_reg) - 1'b1))
        else $error("dequeue count mismatch");

    // every accepted command leaves a result word pending
    a_result_pending: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> out_valid_reg)
        else $error("result word lost");

endmodule

`default_nettype wire

// File: test/priority_queue_max_first_monitor.sv
`timescale 1ns / 1ps
// priority_queue_max_first_monitor: watches both streams of the max-first queue,
// keeps its own copy of the store and scores every result word
// depends on pqmf_pkg
module priority_queue_max_first_monitor #(
    parameter int DEPTH         = 16,
    parameter int PRIORITY_BITS = 8
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                s_axis_tvalid,
    input  logic                                s_axis_tready,
    input  logic [pqmf_pkg::IN_DATA_W-1:0]      s_axis_tdata,  // item_value, item_priority
    input  logic [0:0]                          s_axis_tuser,  // op
    input  logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    input  logic [pqmf_pkg::OUT_DATA_W-1:0]     m_axis_tdata,  // out_value, out_priority,
                                                               // occupancy, zero pad
    input  logic [pqmf_pkg::STATUS_W-1:0]       m_axis_tuser,  // status
    output int                                  failures,
    output int                                  pending
);
    import pqmf_pkg::*;

    localparam int PRIO_LSB = VALUE_W;
    localparam int OCC_LSB  = VALUE_W + IN_PRIO_W;
    localparam int PAD_LSB  = VALUE_W + IN_PRIO_W + OCC_W;

    typedef struct packed {
        logic [VALUE_W-1:0]   value;
        logic [IN_PRIO_W-1:0] prio;
        status_t              status;
        logic [OCC_W-1:0]     occ;
    } queue_word_t;

    // shadow store, oldest entry at index 0
    logic [VALUE_W-1:0]       held_value [DEPTH];
    logic [PRIORITY_BITS-1:0] held_prio  [DEPTH];
    int                       held_count;
    queue_word_t              awaited_words [$];

    initial failures = 0;
    initial pending  = 0;

    task automatic report_mismatch(string msg);
        failures++;
        $display("%0t ns: %s", $time, msg);
    endtask

    // apply one command to the shadow store and return the word it should produce
    function automatic queue_word_t serve_command(op_t op, logic [VALUE_W-1:0] value,
                                                  logic [IN_PRIO_W-1:0] prio);
        queue_word_t res;
        int          best;
        res.value  = '0;
        res.prio   = '0;
        res.status = STATUS_OK;
        if (op == OP_ENQUEUE) begin
            if (held_count >= DEPTH) begin
                res.status = STATUS_FULL;
            end
            else begin
                held_value[held_count] = value;
                held_prio[held_count]  = PRIORITY_BITS'(prio);
                held_count++;
            end
        end
        else if (held_count == 0) begin
            res.value  = EMPTY_VALUE;
            res.status = STATUS_EMPTY;
        end
        else begin
            // strict compare keeps the oldest of equal priorities
            best = 0;
            for (int k = 1; k < held_count; k++)
                if (held_prio[k] > held_prio[best])
                    best = k;
            res.value = held_value[best];
            res.prio  = IN_PRIO_W'(held_prio[best]);
            for (int k = best; k + 1 < held_count; k++) begin
                held_value[k] = held_value[k + 1];
                held_prio[k]  = held_prio[k + 1];
            end
            held_count--;
        end
        res.occ = OCC_W'(held_count);
        return res;
    endfunction

    always @(posedge clk or negedge rst_n) begin
        queue_word_t got;
        queue_word_t want;
        if (!rst_n) begin
            held_count = 0;
            awaited_words.delete();
            pending = 0;
        end
        else begin
            // result first: a word leaving at this edge belongs to an earlier command
            if (m_axis_tvalid && m_axis_tready) begin
                got.value  = m_axis_tdata[VALUE_W-1:0];
                got.prio   = m_axis_tdata[PRIO_LSB +: IN_PRIO_W];
                got.occ    = m_axis_tdata[OCC_LSB +: OCC_W];
                got.status = status_t'(m_axis_tuser);
                if (awaited_words.size() == 0) begin
                    report_mismatch($sformatf("result word %h with no command outstanding",
                                              m_axis_tdata));
                end
                else begin
                    want = awaited_words.pop_front();
                    if (got.value !== want.value)
                        report_mismatch($sformatf("out_value got %h expected %h",
                                                  got.value, want.value));
                    if (got.prio !== want.prio)
                        report_mismatch($sformatf("out_priority got %h expected %h",
                                                  got.prio, want.prio));
                    if (got.status !== want.status)
                        report_mismatch($sformatf("status got %0d expected %0d",
                                                  got.status, want.status));
                    if (got.occ !== want.occ)
                        report_mismatch($sformatf("occupancy got %0d expected %0d",
                                                  got.occ, want.occ));
                    if (m_axis_tdata[OUT_DATA_W-1:PAD_LSB] !== '0)
                        report_mismatch($sformatf("pad bits not zero in %h", m_axis_tdata));
                end
            end
            if (s_axis_tvalid && s_axis_tready)
                awaited_words.push_back(serve_command(op_t'(s_axis_tuser),
                                                      s_axis_tdata[VALUE_W-1:0],
                                                      s_axis_tdata[PRIO_LSB +: IN_PRIO_W]));
            pending = awaited_words.size();
        end
    end

endmodule

// File: test/priority_queue_max_first_tb.sv
`timescale 1ns / 1ps
// priority_queue_max_first_tb: stimulus and verdict for the max-first priority queue
// depends on pqmf_pkg, priority_queue_max_first and priority_queue_max_first_monitor
module priority_queue_max_first_tb;
    import pqmf_pkg::*;

    localparam int HOLD_CYCLES = 60;   // long receiver stall for the backpressure phase
    localparam int SEGMENTS    = 14;   // random segments of 100 words each

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    logic                      s_axis_tvalid = 1'b0;
    logic                      s_axis_tready;
    logic [IN_DATA_W-1:0]      s_axis_tdata  = '0;  // item_value, item_priority
    logic [0:0]                s_axis_tuser  = OP_ENQUEUE;  // op
    logic                      m_axis_tvalid;
    logic                      m_axis_tready = 1'b0;
    logic [OUT_DATA_W-1:0]     m_axis_tdata;  // out_value, out_priority, occupancy, zero pad
    logic [STATUS_W-1:0]       m_axis_tuser;  // status

    int failures;
    int pending;

    // idling controls shared by the sender and receiver processes
    logic tx_steady = 1'b0;  // sender offers words back to back
    logic rx_steady = 1'b0;  // receiver never drops tready on its own
    logic hold_req  = 1'b0;  // receiver to take one long stall

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    priority_queue_max_first u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    priority_queue_max_first_monitor u_check (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .failures      (failures),
        .pending       (pending)
    );

    // offer one command word; all driving happens at the falling edge
    task automatic send_command(op_t op, logic [VALUE_W-1:0] value,
                                logic [IN_PRIO_W-1:0] prio);
        int gap;
        gap = tx_steady ? 0 : $urandom_range(0, 10);
        if (gap != 0)
        begin
            s_axis_tvalid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_axis_tvalid = 1'b1;
        s_axis_tuser  = op;
        s_axis_tdata  = {prio, value};
        do @(posedge clk); while (!s_axis_tready);
        @(negedge clk);
    endtask

    // sender pause until every outstanding result word has come back
    task automatic wait_drained();
        s_axis_tvalid = 1'b0;
        while (pending != 0) @(negedge clk);
    endtask

    // receiver: random stall before each word, plus one long hold on request
    initial
    begin
        int stall;
        wait (rst_n);
        forever
        begin
            if (hold_req)
            begin
                hold_req      = 1'b0;
                m_axis_tready = 1'b0;
                repeat (HOLD_CYCLES) @(negedge clk);
            end
            else if (!rx_steady)
            begin
                stall = $urandom_range(0, 10);
                if (stall != 0)
                begin
                    m_axis_tready = 1'b0;
                    repeat (stall) @(negedge clk);
                end
            end
            m_axis_tready = 1'b1;
            do @(posedge clk); while (!m_axis_tvalid);
            @(negedge clk);
        end
    end

    // hard stop in case the handshake hangs
    initial
    begin
        #(5_000_000);
        $display("Test completed with failures");
        $finish;
    end

    initial
    begin
        op_t                  op;
        logic [IN_PRIO_W-1:0] prio;
        int                   enq_pct;
        logic                 wide_prio;
        int                   drain;

        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // dequeue on an empty store, with junk in the ignored fields
        send_command(OP_DEQUEUE, 32'h1234_5678, 8'hAB);
        // value and priority extremes; the third ties the first and must leave second
        send_command(OP_ENQUEUE, 32'h7FFF_FFFF, 8'hFF);
        send_command(OP_ENQUEUE, 32'h8000_0000, 8'h00);
        send_command(OP_ENQUEUE, 32'h0000_0000, 8'hFF);
        send_command(OP_ENQUEUE, 32'hFFFF_FFFF, 8'h01);
        repeat (4) send_command(OP_DEQUEUE, $urandom, IN_PRIO_W'($urandom_range(0, 255)));
        send_command(OP_DEQUEUE, 32'hFFFF_FFFF, 8'hFF);

        // backpressure: receiver holds off while the sender pushes past full
        wait_drained();
        hold_req  = 1'b1;
        tx_steady = 1'b1;
        repeat (18) send_command(OP_ENQUEUE, $urandom, IN_PRIO_W'($urandom_range(0, 255)));
        tx_steady = 1'b0;
        // drain to empty and one more for the empty status
        repeat (17) send_command(OP_DEQUEUE, $urandom, IN_PRIO_W'($urandom_range(0, 255)));

        // random segments, each with its own enqueue bias and priority spread
        for (int seg = 0; seg < SEGMENTS; seg++)
        begin
            enq_pct   = $urandom_range(15, 90);
            wide_prio = ($urandom_range(0, 2) == 0);
            tx_steady = (seg % 4 == 2);
            rx_steady = (seg % 4 == 2) || (seg % 5 == 4);
            if (seg == SEGMENTS / 2)
                wait_drained();
            for (int i = 0; i < 100; i++)
            begin
                op = ($urandom_range(1, 100) <= enq_pct) ? OP_ENQUEUE : OP_DEQUEUE;
                if (wide_prio)
                begin
                    prio = IN_PRIO_W'($urandom_range(0, 255));
                end
                else
                begin
                    // narrow set {0, 1, 254, 255} gives lots of ties
                    prio = IN_PRIO_W'($urandom_range(0, 3));
                    if (prio >= 2)
                        prio = prio + 8'd252;
                end
                send_command(op, $urandom, prio);
            end
        end
        tx_steady = 1'b0;
        rx_steady = 1'b0;

        // let the last words come back, then a few spare cycles
        s_axis_tvalid = 1'b0;
        drain = 0;
        while (pending != 0 && drain < 2000)
        begin
            @(negedge clk);
            drain++;
        end
        repeat (5) @(negedge clk);

        if (failures == 0 && pending == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

// File: filelist.f
sv/pqmf_pkg.sv
sv/pqmf_cell.sv
sv/priority_queue_max_first.sv
test/priority_queue_max_first_monitor.sv
test/priority_queue_max_first_tb.sv
